// ===== hw/rtl/rti_pkg.sv =====
// rti_pkg: shared types, constants and the multiply-accumulate microcode
// for the ray/triangle intersection block; depends on nothing
package rti_pkg;

  localparam int MAX_TRIANGLES_DEF = 256;

  localparam int COORD_W = 32;   // q16.16 coordinate
  localparam int EDGE_W  = 33;   // difference of two coordinates
  localparam int CROSS_W = 68;   // cross product component
  localparam int ACC_W   = 104;  // dot product of an edge and a cross product
  localparam int ADD_W   = 136;  // shared adder, also holds the shifted divisor
  localparam int DIST_W  = 31;
  localparam int EPS_W   = 16;
  localparam int NUM_UOPS = 24;
  localparam int DATA_W  = 208;  // input tdata, padded to whole bytes

  typedef enum logic [1:0] {A_E1, A_E2, A_H, A_Q} a_src_t;
  typedef enum logic [1:0] {B_DIR, B_E1, B_S, B_E2} b_src_t;
  typedef enum logic [2:0] {D_NONE, D_H, D_Q, D_DET, D_U, D_V, D_T} dst_t;

  typedef struct packed {
    a_src_t     asrc;
    logic [1:0] aidx;
    b_src_t     bsrc;
    logic [1:0] bidx;
    logic       neg;
    logic       first;
    dst_t       dst;
    logic [1:0] didx;
  } uop_t;

  // one product per entry: acc (+/-)= a * b, result stored on the last of a group
  function automatic uop_t ucode(input logic [4:0] st);
    uop_t r;
    unique case (st)
      5'd0:  r = '{A_E2, 2'd2, B_DIR, 2'd1, 1'b0, 1'b1, D_NONE, 2'd0};
      5'd1:  r = '{A_E2, 2'd1, B_DIR, 2'd2, 1'b1, 1'b0, D_H,    2'd0};
      5'd2:  r = '{A_E2, 2'd0, B_DIR, 2'd2, 1'b0, 1'b1, D_NONE, 2'd0};
      5'd3:  r = '{A_E2, 2'd2, B_DIR, 2'd0, 1'b1, 1'b0, D_H,    2'd1};
      5'd4:  r = '{A_E2, 2'd1, B_DIR, 2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
      5'd5:  r = '{A_E2, 2'd0, B_DIR, 2'd1, 1'b1, 1'b0, D_H,    2'd2};
      5'd6:  r = '{A_H,  2'd0, B_E1,  2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
      5'd7:  r = '{A_H,  2'd1, B_E1,  2'd1, 1'b0, 1'b0, D_NONE, 2'd0};
      5'd8:  r = '{A_H,  2'd2, B_E1,  2'd2, 1'b0, 1'b0, D_DET,  2'd0};
      5'd9:  r = '{A_H,  2'd0, B_S,   2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
      5'd10: r = '{A_H,  2'd1, B_S,   2'd1, 1'b0, 1'b0, D_NONE, 2'd0};
      5'd11: r = '{A_H,  2'd2, B_S,   2'd2, 1'b0, 1'b0, D_U,    2'd0};
      5'd12: r = '{A_E1, 2'd2, B_S,   2'd1, 1'b0, 1'b1, D_NONE, 2'd0};
      5'd13: r = '{A_E1, 2'd1, B_S,   2'd2, 1'b1, 1'b0, D_Q,    2'd0};
      5'd14: r = '{A_E1, 2'd0, B_S,   2'd2, 1'b0, 1'b1, D_NONE, 2'd0};
      5'd15: r = '{A_E1, 2'd2, B_S,   2'd0, 1'b1, 1'b0, D_Q,    2'd1};
      5'd16: r = '{A_E1, 2'd1, B_S,   2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
      5'd17: r = '{A_E1, 2'd0, B_S,   2'd1, 1'b1, 1'b0, D_Q,    2'd2};
      5'd18: r = '{A_Q,  2'd0, B_DIR, 2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
      5'd19: r = '{A_Q,  2'd1, B_DIR, 2'd1, 1'b0, 1'b0, D_NONE, 2'd0};
      5'd20: r = '{A_Q,  2'd2, B_DIR, 2'd2, 1'b0, 1'b0, D_V,    2'd0};
      5'd21: r = '{A_Q,  2'd0, B_E2,  2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
      5'd22: r = '{A_Q,  2'd1, B_E2,  2'd1, 1'b0, 1'b0, D_NONE, 2'd0};
      5'd23: r = '{A_Q,  2'd2, B_E2,  2'd2, 1'b0, 1'b0, D_T,    2'd0};
      default: r = '{A_E1, 2'd0, B_DIR, 2'd0, 1'b0, 1'b0, D_NONE, 2'd0};
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/ray_triangle_intersect.sv =====
// ray_triangle_intersect: triangle vertex store and single-sided ray test
// depends on rti_pkg and rti_ram
//
//  channel  dir  payload
//  s_*      in   tuser: cmd; tdata: tri_index, corner, px, py, pz, dir_x, dir_y, dir_z
//  m_*      out  tuser: hit; tdata: distance
//  cfg_*    in   cfg_data: det_epsilon
//
// one item at a time; s_tready is high only while the sequencer is idle.
// a vertex write goes from its transfer back to ready through: transfer, slot
// wrap, 3 ram writes, finish and output. a query goes through: transfer, wrap,
// the ram reads, prep, 24 shift-add products on the one adder, the compare states,
// an overflow check and the divide steps, finish and output. the slot wrap
// repeats once per subtraction of MAX_TRIANGLES. the output state holds until the
// previous result is taken, then it waits in the output register while the next
// item is taken. synchronous reset clears control state only.
module ray_triangle_intersect #(
  parameter int MAX_TRIANGLES = rti_pkg::MAX_TRIANGLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic                       s_tuser,   // cmd
  // tri_index, corner, px, py, pz, dir_x, dir_y, dir_z, zero pad
  input  logic [rti_pkg::DATA_W-1:0] s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic                       m_tuser,   // hit
  output logic [31:0]                m_tdata,   // distance, zero pad
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rti_pkg::EPS_W-1:0]  cfg_data   // det_epsilon
);

  localparam int DEPTH = MAX_TRIANGLES * 9;
  localparam int AW    = $clog2(DEPTH);
  localparam int ACC_W = rti_pkg::ACC_W;
  localparam int ADD_W = rti_pkg::ADD_W;
  localparam int HW    = rti_pkg::CROSS_W;
  localparam int EW    = rti_pkg::EDGE_W;
  localparam int CW    = rti_pkg::COORD_W;
  localparam int QW    = rti_pkg::DIST_W;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_WRAP   = 15'h0002,
    S_WR     = 15'h0004,
    S_RD     = 15'h0008,
    S_PREP   = 15'h0010,
    S_LOAD   = 15'h0020,
    S_MUL    = 15'h0040,
    S_CHK_E  = 15'h0080,
    S_CHK_U  = 15'h0100,
    S_SUM_UV = 15'h0200,
    S_CHK_V  = 15'h0400,
    S_DIV_S  = 15'h0800,
    S_DIV    = 15'h1000,
    S_FIN    = 15'h2000,
    S_OUT    = 15'h4000
  } state_t;

  state_t state;

  logic [rti_pkg::EPS_W-1:0] eps;
  logic                      cmd;
  logic [7:0]                slot;
  logic [1:0]                corner;
  logic signed [CW-1:0]      orig [3];
  logic signed [CW-1:0]      dirv [3];
  logic [CW-1:0]             vraw [9];
  logic signed [EW-1:0]      e1 [3];
  logic signed [EW-1:0]      e2 [3];
  logic signed [EW-1:0]      sv [3];
  logic signed [HW-1:0]      h [3];
  logic signed [HW-1:0]      qv [3];
  logic signed [ACC_W-1:0]   det, uu, vv, tt;
  logic signed [ACC_W-1:0]   acc, acc_next, mcand;
  logic [EW-1:0]             mplier;
  logic [5:0]                mc;
  logic [4:0]                st;
  logic [3:0]                cnt;
  logic [ADD_W-1:0]          rem, dsh, uv;
  logic [QW-1:0]             quo;
  logic                      miss;
  logic                      hit_r;
  logic [QW-1:0]             dist_r;

  logic [ADD_W-1:0]          add_a, add_b, add_sum;
  logic                      add_sub;
  logic                      add_neg;
  rti_pkg::uop_t             uop;
  logic signed [HW-1:0]      a_val;
  logic signed [EW-1:0]      b_val;
  logic [AW-1:0]             base;
  logic [3:0]                corner_off;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr, rd_addr;
  logic [CW-1:0]             wr_data, rd_data;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tuser   = hit_r;
  assign m_tdata   = {1'b0, dist_r};

  // slot * 9, slot never exceeds 255
  assign base       = AW'(({4'b0, slot} << 3) + {4'b0, slot});
  assign corner_off = ({2'b0, corner} << 1) + {2'b0, corner};

  assign wr_en   = (state == S_WR);
  assign wr_addr = base + AW'(corner_off) + AW'(cnt);
  assign wr_data = orig[cnt[1:0]];
  assign rd_addr = base + AW'((cnt == 4'd9) ? 4'd0 : cnt);

  rti_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_vram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign uop = rti_pkg::ucode(st);

  always_comb begin
    unique case (uop.asrc)
      rti_pkg::A_E1: a_val = HW'(e1[uop.aidx]);
      rti_pkg::A_E2: a_val = HW'(e2[uop.aidx]);
      rti_pkg::A_H:  a_val = h[uop.aidx];
      rti_pkg::A_Q:  a_val = qv[uop.aidx];
      default:       a_val = '0;
    endcase
    unique case (uop.bsrc)
      rti_pkg::B_DIR: b_val = EW'(dirv[uop.bidx]);
      rti_pkg::B_E1:  b_val = e1[uop.bidx];
      rti_pkg::B_S:   b_val = sv[uop.bidx];
      rti_pkg::B_E2:  b_val = e2[uop.bidx];
      default:        b_val = '0;
    endcase
  end

  // the one shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state)
      S_LOAD: begin
        add_b   = ADD_W'(a_val);
        add_sub = uop.neg;
      end
      S_MUL: begin
        add_a   = ADD_W'(acc);
        add_b   = ADD_W'(mcand);
        add_sub = (mc == 6'd32);   // sign bit of the multiplier weighs negative
      end
      S_CHK_E: begin
        add_a   = ADD_W'(det);
        add_b   = ADD_W'({eps, 32'b0});
        add_sub = 1'b1;
      end
      S_CHK_U: begin
        add_a   = ADD_W'(det);
        add_b   = ADD_W'(uu);
        add_sub = 1'b1;
      end
      S_SUM_UV: begin
        add_a = ADD_W'(uu);
        add_b = ADD_W'(vv);
      end
      S_CHK_V: begin
        add_a   = ADD_W'(det);
        add_b   = uv;
        add_sub = 1'b1;
      end
      S_DIV_S, S_DIV: begin
        add_a   = rem;
        add_b   = dsh;
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_sum = add_a + (add_b ^ {ADD_W{add_sub}}) + ADD_W'(add_sub);
  assign add_neg = add_sum[ADD_W-1];

  assign acc_next = mplier[0] ? add_sum[ACC_W-1:0] : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      eps      <= rti_pkg::EPS_W'(1);
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        eps <= cfg_data;
      end
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd     <= s_tuser;
            slot    <= s_tdata[7:0];
            corner  <= s_tdata[9:8];
            orig[0] <= s_tdata[41:10];
            orig[1] <= s_tdata[73:42];
            orig[2] <= s_tdata[105:74];
            dirv[0] <= s_tdata[137:106];
            dirv[1] <= s_tdata[169:138];
            dirv[2] <= s_tdata[201:170];
            cnt     <= '0;
            miss    <= 1'b0;
            quo     <= '0;
            state   <= S_WRAP;
          end
        end

        // slot index modulo the table size
        S_WRAP: begin
          if (32'(slot) >= MAX_TRIANGLES) begin
            slot <= slot - 8'(MAX_TRIANGLES);
          end else if (cmd) begin
            state <= S_RD;
          end else if (corner == 2'd3) begin
            miss  <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_WR;
          end
        end

        S_WR: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd2) begin
            miss  <= 1'b1;
            state <= S_FIN;
          end
        end

        S_RD: begin
          if (cnt != 4'd0) begin
            vraw[cnt - 4'd1] <= rd_data;
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd9) begin
            state <= S_PREP;
          end
        end

        S_PREP: begin
          for (int k = 0; k < 3; k++) begin
            e1[k] <= EW'($signed(vraw[3 + k])) - EW'($signed(vraw[k]));
            e2[k] <= EW'($signed(vraw[6 + k])) - EW'($signed(vraw[k]));
            sv[k] <= EW'(orig[k]) - EW'($signed(vraw[k]));
          end
          st    <= '0;
          state <= S_LOAD;
        end

        S_LOAD: begin
          mcand  <= $signed(add_sum[ACC_W-1:0]);
          mplier <= b_val;
          mc     <= '0;
          if (uop.first) begin
            acc <= '0;
          end
          state <= S_MUL;
        end

        S_MUL: begin
          acc    <= acc_next;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          mc     <= mc + 6'd1;
          if (mc == 6'd32) begin
            unique case (uop.dst)
              rti_pkg::D_H:   h[uop.didx]  <= acc_next[HW-1:0];
              rti_pkg::D_Q:   qv[uop.didx] <= acc_next[HW-1:0];
              rti_pkg::D_DET: det <= acc_next;
              rti_pkg::D_U:   uu  <= acc_next;
              rti_pkg::D_V:   vv  <= acc_next;
              rti_pkg::D_T:   tt  <= acc_next;
              default: ;
            endcase
            st <= st + 5'd1;
            state <= (st == 5'(rti_pkg::NUM_UOPS - 1)) ? S_CHK_E : S_LOAD;
          end
        end

        S_CHK_E: begin
          if (add_neg || det[ACC_W-1] || (det == '0)) begin
            miss <= 1'b1;
          end
          state <= S_CHK_U;
        end

        S_CHK_U: begin
          if (add_neg || uu[ACC_W-1]) begin
            miss <= 1'b1;
          end
          state <= S_SUM_UV;
        end

        S_SUM_UV: begin
          uv    <= add_sum;
          state <= S_CHK_V;
        end

        S_CHK_V: begin
          rem <= ADD_W'(tt) << 16;
          dsh <= ADD_W'(det) << 31;
          if (miss || add_neg || vv[ACC_W-1] || tt[ACC_W-1]) begin
            miss  <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_DIV_S;
          end
        end

        // quotient would need more than 31 bits: saturate
        S_DIV_S: begin
          if (!add_neg) begin
            quo   <= '1;
            state <= S_FIN;
          end else begin
            dsh   <= dsh >> 1;
            cnt   <= '0;
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (!add_neg) begin
            rem <= add_sum;
          end
          quo <= {quo[QW-2:0], !add_neg};
          dsh <= dsh >> 1;
          // last step divides by det itself
          if (dsh == ADD_W'(det)) begin
            state <= S_FIN;
          end
        end

        S_FIN: begin
          state <= S_OUT;
        end

        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            hit_r    <= !miss && (quo >= QW'(eps));
            dist_r   <= (!miss && (quo >= QW'(eps))) ? quo : '0;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rti_ram.sv =====
// rti_ram: generic single write port, single read port ram with registered read
// no dependencies
module rti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2304
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
